// ===== src/wls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wls_pkg
// Shared widths, register indexes and types for the windowed level
// statistics block.
// ----------------------------------------------------------------------------
package wls_pkg;

  localparam int LEVEL_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int COUNT_W    = 32;
  localparam int TOTAL_W    = 48;
  localparam int Q8_SHIFT   = 8;
  localparam int DIVIDEND_W = TOTAL_W + Q8_SHIFT;
  localparam int STEP_W     = $clog2(DIVIDEND_W + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [FIELD_W-1:0] LEVEL_MASK   = FIELD_W'((1 << LEVEL_BITS) - 1);
  localparam logic [FIELD_W-1:0] WINDOW_RESET = FIELD_W'(50);
  localparam logic [COUNT_W-1:0] COUNT_LIMIT  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_STATS_ENABLE  = 2'd1
  } cfg_index_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  // Window snapshot handed from the front to the divider.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
    logic [FIELD_W-1:0] lowest;
    logic [FIELD_W-1:0] highest;
    logic [FIELD_W-1:0] newest;
  } snap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== src/wls_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wls_front
// Takes level samples, keeps the running window statistics and the
// configuration registers, and pushes a snapshot when a window closes.
// ----------------------------------------------------------------------------
module wls_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wls_pkg::FIELD_W-1:0]   in_level,
  input  logic                          cfg_wr_en,
  input  logic [wls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wls_pkg::FIELD_W-1:0]   cfg_wdata,
  input  wls_pkg::fifo_stat_t           fifo_stat,
  output logic                          push,
  output wls_pkg::snap_t                push_data
);

  logic [wls_pkg::FIELD_W-1:0] window_length_r;
  logic                        stats_enable_r;
  logic [wls_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [wls_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [wls_pkg::FIELD_W-1:0] min_r, min_nxt;
  logic [wls_pkg::FIELD_W-1:0] max_r, max_nxt;
  logic [wls_pkg::FIELD_W-1:0] last_r, last_nxt;
  logic [wls_pkg::FIELD_W-1:0] lv;
  logic                        accept;
  logic                        emit;

  assign in_stall = fifo_stat.full;
  assign accept   = in_valid && !in_stall;
  assign lv       = wls_pkg::FIELD_W'(in_level[wls_pkg::LEVEL_BITS-1:0]);

  always_comb begin
    last_nxt = lv;
    min_nxt  = (lv < min_r) ? lv : min_r;
    max_nxt  = (lv > max_r) ? lv : max_r;
    // hold count and total once the count saturates
    if (count_r != wls_pkg::COUNT_LIMIT) begin
      count_nxt = count_r + wls_pkg::COUNT_W'(1);
      total_nxt = total_r + wls_pkg::TOTAL_W'(lv);
    end else begin
      count_nxt = count_r;
      total_nxt = total_r;
    end
    emit = stats_enable_r && (count_nxt >= wls_pkg::COUNT_W'(window_length_r));
  end

  assign push              = accept && emit;
  assign push_data.count   = count_nxt;
  assign push_data.total   = total_nxt;
  assign push_data.lowest  = (min_nxt == wls_pkg::LEVEL_MASK) ? '0 : min_nxt;
  assign push_data.highest = max_nxt;
  assign push_data.newest  = last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= wls_pkg::WINDOW_RESET;
      stats_enable_r  <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        wls_pkg::CFG_WINDOW_LENGTH: window_length_r <= cfg_wdata;
        wls_pkg::CFG_STATS_ENABLE:  stats_enable_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
      min_r   <= wls_pkg::LEVEL_MASK;
      max_r   <= '0;
      last_r  <= '0;
    end else if (accept) begin
      if (emit) begin
        // drop the window once its snapshot is queued
        count_r <= '0;
        total_r <= '0;
        min_r   <= wls_pkg::LEVEL_MASK;
        max_r   <= '0;
        last_r  <= '0;
      end else begin
        count_r <= count_nxt;
        total_r <= total_nxt;
        min_r   <= min_nxt;
        max_r   <= max_nxt;
        last_r  <= last_nxt;
      end
    end
  end

endmodule

// ===== src/wls_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wls_fifo
// Short snapshot queue between the front and the divider.
// ----------------------------------------------------------------------------
module wls_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wls_pkg::snap_t      push_data,
  input  logic                pop,
  output wls_pkg::snap_t      pop_data,
  output wls_pkg::fifo_stat_t fifo_stat
);

  wls_pkg::snap_t                  mem [wls_pkg::FIFO_DEPTH];
  logic [wls_pkg::FIFO_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [wls_pkg::FIFO_CNT_W-1:0]  cnt_r;

  assign fifo_stat.full  = (cnt_r == wls_pkg::FIFO_CNT_W'(wls_pkg::FIFO_DEPTH));
  assign fifo_stat.empty = (cnt_r == '0);
  assign pop_data        = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + wls_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + wls_pkg::FIFO_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + wls_pkg::FIFO_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - wls_pkg::FIFO_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== src/wls_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wls_back
// Pops snapshots, computes the Q8 mean with a restoring divider (one
// quotient bit per cycle) and holds the finished request in the output
// register.
// ----------------------------------------------------------------------------
module wls_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wls_pkg::fifo_stat_t         fifo_stat,
  input  wls_pkg::snap_t              pop_data,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wls_pkg::FIELD_W-1:0] out_window_count,
  output logic [wls_pkg::FIELD_W-1:0] out_level_min,
  output logic [wls_pkg::FIELD_W-1:0] out_level_max,
  output logic [wls_pkg::FIELD_W-1:0] out_level_last,
  output logic [wls_pkg::FIELD_W-1:0] out_level_mean_q8
);

  wls_pkg::div_state_t state_r, state_nxt;

  logic [wls_pkg::COUNT_W-1:0]    divisor_r, divisor_nxt;
  logic [wls_pkg::COUNT_W-1:0]    rem_r, rem_nxt;
  logic [wls_pkg::DIVIDEND_W-1:0] dq_r, dq_nxt;
  logic [wls_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [wls_pkg::FIELD_W-1:0]    min_r, min_nxt;
  logic [wls_pkg::FIELD_W-1:0]    max_r, max_nxt;
  logic [wls_pkg::FIELD_W-1:0]    last_r, last_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [wls_pkg::FIELD_W-1:0]    o_count_r, o_min_r, o_max_r, o_last_r, o_mean_r;
  logic                           load_out;

  logic [wls_pkg::COUNT_W:0]      trial;
  logic [wls_pkg::COUNT_W:0]      diff;
  logic                           ge;

  assign trial = {rem_r, dq_r[wls_pkg::DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, divisor_r};
  assign ge    = (trial >= {1'b0, divisor_r});

  always_comb begin
    state_nxt   = state_r;
    divisor_nxt = divisor_r;
    rem_nxt     = rem_r;
    dq_nxt      = dq_r;
    step_nxt    = step_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    last_nxt    = last_r;
    pop         = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      wls_pkg::DIV_IDLE: begin
        if (!fifo_stat.empty) begin
          pop         = 1'b1;
          divisor_nxt = pop_data.count;
          rem_nxt     = '0;
          dq_nxt      = {pop_data.total, wls_pkg::Q8_SHIFT'(0)};
          step_nxt    = wls_pkg::STEP_W'(wls_pkg::DIVIDEND_W);
          min_nxt     = pop_data.lowest;
          max_nxt     = pop_data.highest;
          last_nxt    = pop_data.newest;
          state_nxt   = wls_pkg::DIV_RUN;
        end
      end
      wls_pkg::DIV_RUN: begin
        rem_nxt  = ge ? diff[wls_pkg::COUNT_W-1:0] : trial[wls_pkg::COUNT_W-1:0];
        dq_nxt   = {dq_r[wls_pkg::DIVIDEND_W-2:0], ge};
        step_nxt = step_r - wls_pkg::STEP_W'(1);
        if (step_r == wls_pkg::STEP_W'(1)) begin
          state_nxt = wls_pkg::DIV_DONE;
        end
      end
      wls_pkg::DIV_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = wls_pkg::DIV_IDLE;
        end
      end
      default: state_nxt = wls_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wls_pkg::DIV_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    divisor_r <= divisor_nxt;
    rem_r     <= rem_nxt;
    dq_r      <= dq_nxt;
    step_r    <= step_nxt;
    min_r     <= min_nxt;
    max_r     <= max_nxt;
    last_r    <= last_nxt;
    if (load_out) begin
      o_count_r <= divisor_r[wls_pkg::FIELD_W-1:0];
      o_min_r   <= min_r;
      o_max_r   <= max_r;
      o_last_r  <= last_r;
      o_mean_r  <= dq_r[wls_pkg::FIELD_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_window_count  = o_count_r;
  assign out_level_min     = o_min_r;
  assign out_level_max     = o_max_r;
  assign out_level_last    = o_last_r;
  assign out_level_mean_q8 = o_mean_r;

endmodule

// ===== src/windowed_level_statistics_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_level_statistics_core
// Windowed min / max / last / Q8 mean statistics over buffer fill levels.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_level): one level sample per
// request; a sample is taken while the snapshot queue has room.
// Output channel (out_valid / out_stall / out_*): one snapshot request each
// time the sample count reaches window_length while stats_enable is set.
// Config port (cfg_wr_en / cfg_index / cfg_wdata): index 0 is window_length,
// index 1 is stats_enable; other indexes are ignored.
// From the closing sample to out_valid, the divider pops the two-entry
// snapshot queue, runs 56 restoring divide steps for (sum * 256) / count
// and loads the output register. The divider takes a new snapshot only
// after the last one has gone to the output register; samples that close
// no window are taken every cycle until the queue fills, then in_stall rises.
// While out_stall holds a result, the divider finishes the next snapshot and
// waits; the front keeps accumulating until the queue is full.
// Reset sets window_length to 50 and stats_enable to 1, clears the window
// and drops any queued or pending snapshot.
// ----------------------------------------------------------------------------
module windowed_level_statistics_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wls_pkg::FIELD_W-1:0]   in_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wls_pkg::FIELD_W-1:0]   out_window_count,
  output logic [wls_pkg::FIELD_W-1:0]   out_level_min,
  output logic [wls_pkg::FIELD_W-1:0]   out_level_max,
  output logic [wls_pkg::FIELD_W-1:0]   out_level_last,
  output logic [wls_pkg::FIELD_W-1:0]   out_level_mean_q8,
  input  logic                          cfg_wr_en,
  input  logic [wls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wls_pkg::FIELD_W-1:0]   cfg_wdata
);

  wls_pkg::fifo_stat_t fifo_stat;
  wls_pkg::snap_t      push_data;
  wls_pkg::snap_t      pop_data;
  logic                push;
  logic                pop;

  wls_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_level  (in_level),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_data (push_data)
  );

  wls_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .fifo_stat (fifo_stat)
  );

  wls_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .fifo_stat         (fifo_stat),
    .pop_data          (pop_data),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_window_count  (out_window_count),
    .out_level_min     (out_level_min),
    .out_level_max     (out_level_max),
    .out_level_last    (out_level_last),
    .out_level_mean_q8 (out_level_mean_q8)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks windowed_level_statistics_core against a behavioral window model.
// Level samples go in through a valid/stall request port with random gaps.
// The model folds each accepted sample into its own copy of the window, and
// every closed window queues an expected snapshot. Snapshots are taken under
// random output stalls and compared field by field. Config is changed only
// while the block is idle, over several window lengths and enable settings.
// ----------------------------------------------------------------------------
module tb;
  import wls_pkg::*;

  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 80;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 900;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  typedef struct packed {
    logic [FIELD_W-1:0] count;
    logic [FIELD_W-1:0] lowest;
    logic [FIELD_W-1:0] highest;
    logic [FIELD_W-1:0] newest;
    logic [FIELD_W-1:0] mean_q8;
  } level_snapshot_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [FIELD_W-1:0]   in_level;
  logic                 out_valid;
  logic                 out_stall;
  logic [FIELD_W-1:0]   out_window_count;
  logic [FIELD_W-1:0]   out_level_min;
  logic [FIELD_W-1:0]   out_level_max;
  logic [FIELD_W-1:0]   out_level_last;
  logic [FIELD_W-1:0]   out_level_mean_q8;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0]   cfg_wdata;

  // Window model state
  logic [FIELD_W-1:0] window_len;
  logic               stats_on;
  logic [COUNT_W-1:0] seen_count;
  logic [TOTAL_W-1:0] total_acc;
  logic [FIELD_W-1:0] low_level;
  logic [FIELD_W-1:0] high_level;
  logic [FIELD_W-1:0] last_level;

  level_snapshot_t pending_windows[$];
  int unsigned     mismatches = 0;
  int unsigned     send_gap_max = 12;
  int unsigned     sink_stall_max = 12;
  int unsigned     quiet_cycles = 0;

  windowed_level_statistics_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_level          (in_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_window_count  (out_window_count),
    .out_level_min     (out_level_min),
    .out_level_max     (out_level_max),
    .out_level_last    (out_level_last),
    .out_level_mean_q8 (out_level_mean_q8),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void clear_window();
    seen_count = '0;
    total_acc  = '0;
    low_level  = LEVEL_MASK;
    high_level = '0;
    last_level = '0;
  endfunction

  // Fold one sample into the window; queue a snapshot when the window closes.
  function automatic void fold_level(input logic [FIELD_W-1:0] level);
    logic [FIELD_W-1:0] lv;
    logic [63:0]        mean_full;
    level_snapshot_t    snap;
    lv = level & LEVEL_MASK;
    last_level = lv;
    if (lv < low_level) low_level = lv;
    if (lv > high_level) high_level = lv;
    if (seen_count != COUNT_LIMIT) begin
      total_acc  = total_acc + TOTAL_W'(lv);
      seen_count = seen_count + 1'b1;
    end
    if (!stats_on || seen_count < COUNT_W'(window_len)) return;
    mean_full = {8'd0, total_acc, 8'd0} / 64'(seen_count);
    snap.count   = seen_count[FIELD_W-1:0];
    snap.lowest  = (low_level == LEVEL_MASK) ? '0 : low_level;
    snap.highest = high_level;
    snap.newest  = last_level;
    snap.mean_q8 = mean_full[FIELD_W-1:0];
    pending_windows.push_back(snap);
    clear_window();
  endfunction

  task automatic send_level(input logic [FIELD_W-1:0] level);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      in_level <= FIELD_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_level <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_level(level);
  endtask

  // Drop valid, wait for every snapshot, then give the divider time to finish.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [FIELD_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_WINDOW_LENGTH) window_len = data;
    else if (idx == CFG_STATS_ENABLE) stats_on = data[0];
  endtask

  task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%04h, actual 0x%04h", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: random stall per request, then compare with the oldest window.
  initial begin : snapshot_sink
    int unsigned     stall_len;
    level_snapshot_t want;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall_len = $urandom_range(0, sink_stall_max);
      @(negedge clk);
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      if (pending_windows.size() == 0) begin
        $error("snapshot with none expected: count 0x%04h", out_window_count);
        mismatches++;
      end else begin
        want = pending_windows.pop_front();
        check_field("out_window_count", want.count, out_window_count);
        check_field("out_level_min", want.lowest, out_level_min);
        check_field("out_level_max", want.highest, out_level_max);
        check_field("out_level_last", want.newest, out_level_last);
        check_field("out_level_mean_q8", want.mean_q8, out_level_mean_q8);
      end
    end
  end

  // End the run if no request moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Reset values: window of 50 with snapshots on.
  task automatic test_default_window();
    repeat (50) send_level(FIELD_W'($urandom));
    settle_block();
  endtask

  task automatic test_all_ones_minimum();
    write_register(CFG_WINDOW_LENGTH, 16'd3);
    repeat (3) send_level(LEVEL_MASK);
    settle_block();
  endtask

  task automatic test_level_extremes();
    write_register(CFG_WINDOW_LENGTH, 16'd4);
    send_level(16'h0000);
    send_level(16'hFFFF);
    send_level(16'h5555);
    send_level(16'hAAAA);
    settle_block();
  endtask

  // A zero window closes on every sample.
  task automatic test_zero_window();
    write_register(CFG_WINDOW_LENGTH, 16'd0);
    send_level(16'h8000);
    send_level(16'h0001);
    settle_block();
  endtask

  // Largest window holds samples; shrinking it closes on the next one.
  // Writes to unused indexes must leave the window alone.
  task automatic test_window_limits_and_unused_indexes();
    write_register(CFG_WINDOW_LENGTH, 16'hFFFF);
    repeat (3) send_level(FIELD_W'($urandom));
    settle_block();
    write_register(CFG_WINDOW_LENGTH, 16'd1);
    send_level(16'h00FF);
    settle_block();
    write_register(CFG_WINDOW_LENGTH, 16'd2);
    write_register(CFG_UNUSED_A, 16'h0000);
    write_register(CFG_UNUSED_B, 16'hFFFF);
    repeat (2) send_level(FIELD_W'($urandom));
    settle_block();
  endtask

  // Accumulate past the window while off; enabling closes on the next sample.
  task automatic test_enable_after_accumulation();
    write_register(CFG_STATS_ENABLE, 16'hFFFE);
    write_register(CFG_WINDOW_LENGTH, 16'd5);
    repeat (8) send_level(FIELD_W'($urandom));
    settle_block();
    write_register(CFG_STATS_ENABLE, 16'h0003);
    send_level(16'h1234);
    settle_block();
  endtask

  task automatic test_random_windows();
    int unsigned sent;
    int unsigned burst;
    int unsigned pick;
    logic [FIELD_W-1:0] level;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) level = '0;
      else if (pick <= 9) level = FIELD_W'($urandom_range(1, 8));
      else if (pick <= 16) level = FIELD_W'($urandom_range(9, 64));
      else level = FIELD_W'($urandom_range(65, 200));
      write_register(CFG_WINDOW_LENGTH, level);
      write_register(CFG_STATS_ENABLE,
                     {15'($urandom), 1'b0} | FIELD_W'($urandom_range(0, 5) != 0));
      if ($urandom_range(0, 7) == 0)
        write_register($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B,
                       FIELD_W'($urandom));
      pick = $urandom_range(0, 2);
      send_gap_max = (pick == 0) ? 0 : (pick == 1) ? 4 : 12;
      pick = $urandom_range(0, 2);
      sink_stall_max = (pick == 0) ? 0 : (pick == 1) ? 4 : 12;
      burst = $urandom_range(5, 60);
      repeat (burst) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) level = '0;
        else if (pick == 1) level = 16'hFFFF;
        else if (pick <= 3) level = FIELD_W'($urandom_range(0, 255));
        else if (pick == 4) level = FIELD_W'($urandom_range(16'hFF00, 16'hFFFF));
        else level = FIELD_W'($urandom);
        send_level(level);
      end
      sent += burst;
      settle_block();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_level  = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_WINDOW_LENGTH;
    cfg_wdata = '0;
    window_len = WINDOW_RESET;
    stats_on   = 1'b1;
    clear_window();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_default_window();
    test_all_ones_minimum();
    test_level_extremes();
    test_zero_window();
    test_window_limits_and_unused_indexes();
    test_enable_after_accumulation();
    test_random_windows();

    if (mismatches == 0 && pending_windows.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
